// ===== design/iurcc_pkg.sv =====
// Shared types, codes and the CRC-32 byte update for the image update receiver.
package iurcc_pkg;

    // Control packet opcodes
    localparam logic [7:0] OP_START    = 8'h01;
    localparam logic [7:0] OP_COMPLETE = 8'h02;

    // Channel selector values
    localparam logic CH_CONTROL = 1'b0;
    localparam logic CH_DATA    = 1'b1;

    // Storage fault codes sampled at the last byte of a packet
    localparam logic [2:0] FAULT_NONE         = 3'd0;
    localparam logic [2:0] FAULT_NO_PARTITION = 3'd1;
    localparam logic [2:0] FAULT_WRITE        = 3'd2;
    localparam logic [2:0] FAULT_END          = 3'd3;
    localparam logic [2:0] FAULT_BOOT         = 3'd4;

    // Control packet byte counter: saturation point and valid packet length
    localparam logic [2:0] COUNT_SAT  = 3'd6;
    localparam logic [2:0] CTRL_LEN   = 3'd5;

    // Reflected CRC-32 polynomial
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    // Result codes
    typedef enum logic [3:0] {
        CODE_STARTED          = 4'd0,
        CODE_SUCCESS          = 4'd1,
        CODE_EMPTY_CTRL       = 4'd2,
        CODE_BAD_START_LEN    = 4'd3,
        CODE_NO_PARTITION     = 4'd4,
        CODE_BEGIN_FAIL       = 4'd5,
        CODE_COMPLETE_NO_SESS = 4'd6,
        CODE_BAD_COMPLETE_LEN = 4'd7,
        CODE_SIZE_MISMATCH    = 4'd8,
        CODE_CRC_MISMATCH     = 4'd9,
        CODE_END_FAIL         = 4'd10,
        CODE_BOOT_FAIL        = 4'd11,
        CODE_UNKNOWN_CMD      = 4'd12,
        CODE_DATA_NO_SESS     = 4'd13,
        CODE_EMPTY_DATA       = 4'd14,
        CODE_WRITE_FAIL       = 4'd15
    } code_t;

    // One input transaction
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       packet_last;
        logic       packet_empty;
        logic [2:0] storage_fault;
    } item_t;

    // One result transaction
    typedef struct packed {
        code_t code;
        logic  restart;
    } result_t;

    // Chained CRC-32: invert, shift one byte through, invert again
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

endpackage

// ===== design/iurcc_in_reg.sv =====
// Input register stage: holds one accepted transaction until the engine takes it.
module iurcc_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  iurcc_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output iurcc_pkg::item_t item
);

    logic             valid_reg;
    logic             valid_next;
    iurcc_pkg::item_t item_reg;
    logic             accept;

    // Accept while empty or while the held item moves on
    assign s_ready = !valid_reg || take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/iurcc_engine.sv =====
// Session state, control packet assembly, CRC/length tracking and result selection.
module iurcc_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  iurcc_pkg::item_t   item,
    output logic               res_valid,
    output iurcc_pkg::result_t result
);

    logic        active_reg,   active_next;
    logic [31:0] exp_len_reg,  exp_len_next;
    logic [31:0] rx_len_reg,   rx_len_next;
    logic [31:0] crc_reg,      crc_next;
    logic [2:0]  cnt_reg,      cnt_next;
    logic [7:0]  cmd_byte_reg, cmd_byte_next;
    logic [31:0] field_reg,    field_next;

    logic [7:0]  cmd_new;
    logic [31:0] field_new;
    logic [2:0]  cnt_new;
    logic [31:0] crc_upd;

    // Byte-wide CRC step for the current data byte
    assign crc_upd = iurcc_pkg::crc32_byte(crc_reg, item.data_byte);

    // Control assembly: opcode at byte zero, little-endian field in bytes one to four
    always_comb begin
        cmd_new   = cmd_byte_reg;
        field_new = field_reg;
        if (cnt_reg == 3'd0) begin
            cmd_new   = item.data_byte;
            field_new = 32'd0;
        end else begin
            unique case (cnt_reg)
                3'd1:    field_new = field_reg | {24'd0, item.data_byte};
                3'd2:    field_new = field_reg | {16'd0, item.data_byte, 8'd0};
                3'd3:    field_new = field_reg | {8'd0, item.data_byte, 16'd0};
                3'd4:    field_new = field_reg | {item.data_byte, 24'd0};
                default: field_new = field_reg;
            endcase
        end
        cnt_new = (cnt_reg < iurcc_pkg::COUNT_SAT) ? cnt_reg + 3'd1 : cnt_reg;
    end

    // Next state and result for the transaction being processed
    always_comb begin
        active_next    = active_reg;
        exp_len_next   = exp_len_reg;
        rx_len_next    = rx_len_reg;
        crc_next       = crc_reg;
        cnt_next       = cnt_reg;
        cmd_byte_next  = cmd_byte_reg;
        field_next     = field_reg;
        res_valid      = 1'b0;
        result.code    = iurcc_pkg::CODE_STARTED;
        result.restart = 1'b0;

        if (fire) begin
            if (item.cmd == iurcc_pkg::CH_CONTROL) begin
                if (item.packet_empty) begin
                    res_valid   = 1'b1;
                    result.code = iurcc_pkg::CODE_EMPTY_CTRL;
                end else begin
                    cmd_byte_next = cmd_new;
                    field_next    = field_new;
                    cnt_next      = cnt_new;
                    if (item.packet_last) begin
                        cnt_next  = 3'd0;
                        res_valid = 1'b1;
                        if (cmd_new == iurcc_pkg::OP_START) begin
                            if (cnt_new != iurcc_pkg::CTRL_LEN) begin
                                result.code = iurcc_pkg::CODE_BAD_START_LEN;
                            end else begin
                                // Drop any old session and load the new size
                                active_next  = 1'b0;
                                rx_len_next  = 32'd0;
                                crc_next     = 32'd0;
                                exp_len_next = field_new;
                                if (item.storage_fault == iurcc_pkg::FAULT_NO_PARTITION) begin
                                    result.code = iurcc_pkg::CODE_NO_PARTITION;
                                end else if (item.storage_fault == iurcc_pkg::FAULT_WRITE) begin
                                    result.code = iurcc_pkg::CODE_BEGIN_FAIL;
                                end else begin
                                    active_next = 1'b1;
                                    result.code = iurcc_pkg::CODE_STARTED;
                                end
                            end
                        end else if (cmd_new == iurcc_pkg::OP_COMPLETE) begin
                            if (!active_reg) begin
                                result.code = iurcc_pkg::CODE_COMPLETE_NO_SESS;
                            end else begin
                                // Checks in priority order; any failure aborts
                                priority if (cnt_new != iurcc_pkg::CTRL_LEN) begin
                                    result.code = iurcc_pkg::CODE_BAD_COMPLETE_LEN;
                                end else if (rx_len_reg != exp_len_reg) begin
                                    result.code = iurcc_pkg::CODE_SIZE_MISMATCH;
                                end else if (crc_reg != field_new) begin
                                    result.code = iurcc_pkg::CODE_CRC_MISMATCH;
                                end else if (item.storage_fault == iurcc_pkg::FAULT_END) begin
                                    result.code = iurcc_pkg::CODE_END_FAIL;
                                end else if (item.storage_fault == iurcc_pkg::FAULT_BOOT) begin
                                    result.code = iurcc_pkg::CODE_BOOT_FAIL;
                                end else begin
                                    result.code = iurcc_pkg::CODE_SUCCESS;
                                end
                                active_next = 1'b0;
                                if (result.code == iurcc_pkg::CODE_SUCCESS) begin
                                    result.restart = 1'b1;
                                end else begin
                                    exp_len_next = 32'd0;
                                    rx_len_next  = 32'd0;
                                    crc_next     = 32'd0;
                                end
                            end
                        end else begin
                            result.code = iurcc_pkg::CODE_UNKNOWN_CMD;
                        end
                    end
                end
            end else begin
                if (item.packet_empty) begin
                    res_valid   = 1'b1;
                    result.code = active_reg ? iurcc_pkg::CODE_EMPTY_DATA
                                             : iurcc_pkg::CODE_DATA_NO_SESS;
                end else begin
                    // Advance CRC and count only inside a session
                    if (active_reg) begin
                        crc_next    = crc_upd;
                        rx_len_next = rx_len_reg + 32'd1;
                    end
                    if (item.packet_last) begin
                        if (!active_reg) begin
                            res_valid   = 1'b1;
                            result.code = iurcc_pkg::CODE_DATA_NO_SESS;
                        end else if (item.storage_fault == iurcc_pkg::FAULT_WRITE) begin
                            res_valid    = 1'b1;
                            result.code  = iurcc_pkg::CODE_WRITE_FAIL;
                            active_next  = 1'b0;
                            exp_len_next = 32'd0;
                            rx_len_next  = 32'd0;
                            crc_next     = 32'd0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            exp_len_reg  <= 32'd0;
            rx_len_reg   <= 32'd0;
            crc_reg      <= 32'd0;
            cnt_reg      <= 3'd0;
            cmd_byte_reg <= 8'd0;
            field_reg    <= 32'd0;
        end else begin
            active_reg   <= active_next;
            exp_len_reg  <= exp_len_next;
            rx_len_reg   <= rx_len_next;
            crc_reg      <= crc_next;
            cnt_reg      <= cnt_next;
            cmd_byte_reg <= cmd_byte_next;
            field_reg    <= field_next;
        end
    end

endmodule

// ===== design/iurcc_out_reg.sv =====
// Result register: holds one result transaction until the downstream side takes it.
module iurcc_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  iurcc_pkg::result_t res,
    input  logic               m_ready,
    output logic               m_valid,
    output logic               free,
    output iurcc_pkg::result_t m_res
);

    logic               valid_reg;
    logic               valid_next;
    iurcc_pkg::result_t res_reg;

    // Slot is free when empty or drained this cycle
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== design/image_update_receiver_crc_check_core.sv =====
// Top level of the firmware image receiver with CRC-32 check.
// Takes one packet byte per transaction on the s_ side, from either the control channel
// (START / COMPLETE packets) or the data channel, and gives at most one status code per
// byte on the m_ side. A transaction is held in the input register and is then
// processed combinationally into the result register, so the block sustains one byte
// per clock unless the output stalls. The CRC-32 byte update, the 32-bit length compare
// and the session bookkeeping all complete combinationally, in the cycle in which the
// transaction is processed. The input stalls only while a result waits in the output
// register and the downstream side holds m_tready low.
module image_update_receiver_crc_check_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [10:8] storage_fault, [15:11] zero
    input  logic [1:0]  s_tuser,   // [0] cmd, [1] packet_empty
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] code, [7:4] zero
    output logic        m_tuser    // [0] restart
);

    iurcc_pkg::item_t   s_item;
    iurcc_pkg::item_t   item;
    iurcc_pkg::result_t res;
    iurcc_pkg::result_t m_res;
    logic               item_valid;
    logic               res_valid;
    logic               out_free;
    logic               fire;

    // Unpack the input transaction
    assign s_item.cmd           = s_tuser[0];
    assign s_item.packet_empty  = s_tuser[1];
    assign s_item.data_byte     = s_tdata[7:0];
    assign s_item.storage_fault = s_tdata[10:8];
    assign s_item.packet_last   = s_tlast;

    // Process the held item when the result slot can take its outcome
    assign fire = item_valid && out_free;

    iurcc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    iurcc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .result    (res)
    );

    iurcc_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (res_valid),
        .res     (res),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .free    (out_free),
        .m_res   (m_res)
    );

    // Pack the result transaction
    assign m_tdata = {4'd0, m_res.code};
    assign m_tuser = m_res.restart;

endmodule

// ===== design/iurcc_checker.sv =====
// Port-level checker for the image update receiver, bound to the top level.
module iurcc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // Restart comes only with a success code
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[3:0] == iurcc_pkg::CODE_SUCCESS))
        else $error("restart without success code");

    // Success always requests a restart
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[3:0] == iurcc_pkg::CODE_SUCCESS)) |-> m_tuser)
        else $error("success without restart");

    // Padding bits of the result stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:4] == 4'd0))
        else $error("nonzero padding in result");

    // No result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind image_update_receiver_crc_check_core iurcc_checker u_iurcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
